[hw/rtl/dwm_pkg.sv]
// shared types and constants for the decimated window mean per bin block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dwm_pkg;

    localparam int MAX_WINDOW = 128;
    localparam int MAX_BINS   = 128;
    localparam int MAX_STEP   = 1024;

    // register field widths
    localparam int WIN_W  = 8;
    localparam int STEP_W = 11;
    localparam int BINS_W = 8;

    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int BIN_W    = $clog2(MAX_BINS);
    localparam int HIST_AW  = SLOT_W + BIN_W;
    localparam int HIST_DEPTH = MAX_WINDOW * MAX_BINS;

    localparam int SAMPLE_W  = 32;
    localparam int SUM_W     = 40;
    localparam int IDX_W     = 7;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int OUT_TDATA_W = ((SAMPLE_W + IDX_W + 7) / 8) * 8;

    localparam logic [WIN_W-1:0]  WINDOW_RST = WIN_W'(100);
    localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(50);
    localparam logic [BINS_W-1:0] BINS_RST   = BINS_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_STEP   = 2'd1,
        REG_BINS   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_SEND
    } t_state;

    // one read-modify-write of the history and sum stores
    typedef struct packed {
        logic [SLOT_W-1:0]          slot;
        logic [BIN_W-1:0]           bin;
        logic signed [SAMPLE_W-1:0] val;
        logic                       hist_ok;   // history entry written since restart
        logic                       sum_ok;    // sum entry written since restart
    } t_rmw_req;

endpackage

[hw/rtl/dwm_store.sv]
// frame history and per-bin running sum memories with read-modify-write
// depends on dwm_pkg
`timescale 1ns / 1ps

module dwm_store import dwm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rd,       // read both entries of i_req
    input  t_rmw_req                 i_req,
    input  logic                     i_wr,       // write back the request read most recently
    output logic signed [SUM_W-1:0]  o_new_sum
);

    logic signed [SAMPLE_W-1:0] r_hist_mem [HIST_DEPTH];
    logic signed [SUM_W-1:0]    r_sum_mem  [MAX_BINS];

    t_rmw_req                   r_req;
    logic signed [SAMPLE_W-1:0] r_hist_q;
    logic signed [SUM_W-1:0]    r_sum_q;

    logic [HIST_AW-1:0]         rd_addr;
    logic [HIST_AW-1:0]         wr_addr;
    logic signed [SUM_W-1:0]    old_sum;
    logic signed [SUM_W-1:0]    old_val;

    assign rd_addr = {i_req.slot, i_req.bin};
    assign wr_addr = {r_req.slot, r_req.bin};

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_req    <= i_req;
            r_hist_q <= r_hist_mem[rd_addr];
            r_sum_q  <= r_sum_mem[i_req.bin];
        end
    end

    // entries never written since restart read as zero
    assign old_sum   = r_req.sum_ok  ? r_sum_q : '0;
    assign old_val   = r_req.hist_ok ? SUM_W'(r_hist_q) : '0;
    assign o_new_sum = old_sum + SUM_W'($signed(r_req.val)) - old_val;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_hist_mem[wr_addr]  <= r_req.val;
            r_sum_mem[r_req.bin] <= o_new_sum;
        end
    end

endmodule

[hw/rtl/dwm_div.sv]
// serial signed divide of a window sum by the window length, one bit a cycle
// depends on dwm_pkg
`timescale 1ns / 1ps

module dwm_div import dwm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_W-1:0]    i_dividend,
    input  logic [WIN_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [SAMPLE_W-1:0]        o_quot
);

    logic [SUM_W-1:0]     r_q;
    logic [WIN_W-1:0]     r_rem;
    logic [WIN_W-1:0]     r_div;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [SUM_W-1:0]     mag;
    logic [WIN_W:0]       trial;
    logic                 fits;
    logic [WIN_W:0]       diff;
    logic [SUM_W-1:0]     signed_q;

    assign mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign trial = {r_rem, r_q[SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(SUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[SUM_W-2:0], fits};
            r_rem <= fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
        end
    end

    // truncation toward zero: divide magnitudes, then restore sign
    assign signed_q = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_quot   = signed_q[SAMPLE_W-1:0];
    assign o_done   = r_done;

endmodule

[hw/rtl/decimated_window_mean_per_bin_core.sv]
// top level of the decimated boxcar mean per bin: control, registers, output stage
// depends on dwm_pkg, dwm_store, dwm_div
`timescale 1ns / 1ps

//  channel   direction  handshake                  payload
//  s_axis    in         i_s_axis_tvalid/o_tready   tdata: sample; tuser: sample_valid
//  m_axis    out        o_m_axis_tvalid/i_tready   tdata: mean, bin_index; tlast: last_bin
//  cfg       in         i_cfg_valid/o_cfg_ready    index, data (11 bits)
//
//  an item that emits no mean is accepted with a memory read, then written back in S_UPDATE
//  an emitting item goes through accept, update, 40 divide steps, a done cycle, output load
//  the divide loop (one quotient bit per cycle) sets the emitting rate
//  a full output register stalls only the next emitting item, after its divide
//  reset and any write to window, step or bins restart the stream at once: stale history and sums are
//  masked by a frame count, so there is no clearing pass over the memories

module decimated_window_mean_per_bin_core import dwm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]     i_s_axis_tdata,   // [31:0] sample
    input  logic                    i_s_axis_tuser,   // [0] sample_valid
    // output stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,   // [31:0] mean, [38:32] bin_index, rest 0
    output logic                    o_m_axis_tlast,   // last_bin
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // effective (clamped) settings
    logic [WIN_W-1:0]   r_win;
    logic [STEP_W-1:0]  r_step;
    logic [BINS_W-1:0]  r_bins;

    // stream position
    logic [BIN_W-1:0]   r_bin;
    logic [SLOT_W-1:0]  r_slot;
    logic [STEP_W-1:0]  r_until;      // frames left until an emitting frame
    logic [WIN_W-1:0]   r_fcnt;       // frames done since restart, saturates at window

    // item in flight
    logic               r_emit;
    logic [IDX_W-1:0]   r_emit_idx;
    logic               r_emit_last;

    // output register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic [IDX_W-1:0]    r_out_idx;
    logic                r_out_last;

    t_state r_state;
    t_state n_state;

    logic   in_acc;
    logic   cfg_acc;
    logic   cfg_hit;
    logic   do_wr;
    logic   div_start;
    logic   out_load;
    logic   out_free;

    logic [WIN_W-1:0]   n_win;
    logic [STEP_W-1:0]  n_step;
    logic [BINS_W-1:0]  n_bins;
    logic [WIN_W-1:0]   win_m1;

    logic [CFG_DATA_W-1:0] cfg_w8;
    logic                  is_last;
    logic                  emit_now;
    logic [WIN_W-1:0]      slot_inc;

    t_rmw_req                   req;
    logic signed [SUM_W-1:0]    new_sum;
    logic                       div_done;
    logic [SAMPLE_W-1:0]        div_quot;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc         = i_cfg_valid && o_cfg_ready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // ---------------- configuration: clamp on write ----------------
    assign cfg_w8 = {{(CFG_DATA_W-WIN_W){1'b0}}, i_cfg_data[WIN_W-1:0]};

    always_comb begin
        n_win   = r_win;
        n_step  = r_step;
        n_bins  = r_bins;
        cfg_hit = 1'b0;
        if (cfg_acc) begin
            case (i_cfg_index)
                REG_WINDOW: begin
                    cfg_hit = 1'b1;
                    if (cfg_w8 == '0) n_win = WIN_W'(1);
                    else if (cfg_w8 > CFG_DATA_W'(MAX_WINDOW)) n_win = WIN_W'(MAX_WINDOW);
                    else n_win = cfg_w8[WIN_W-1:0];
                end
                REG_STEP: begin
                    cfg_hit = 1'b1;
                    if (i_cfg_data == '0) n_step = STEP_W'(1);
                    else if (i_cfg_data > CFG_DATA_W'(MAX_STEP)) n_step = STEP_W'(MAX_STEP);
                    else n_step = i_cfg_data[STEP_W-1:0];
                end
                REG_BINS: begin
                    cfg_hit = 1'b1;
                    if (cfg_w8 == '0) n_bins = BINS_W'(1);
                    else if (cfg_w8 > CFG_DATA_W'(MAX_BINS)) n_bins = BINS_W'(MAX_BINS);
                    else n_bins = cfg_w8[BINS_W-1:0];
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign win_m1 = n_win - 1'b1;

    // ---------------- per-item position bookkeeping ----------------
    assign is_last  = ({1'b0, r_bin} + 1'b1) == r_bins;
    assign emit_now = (r_until == '0);
    assign slot_inc = {1'b0, r_slot} + 1'b1;

    assign req.slot    = r_slot;
    assign req.bin     = r_bin;
    assign req.val     = i_s_axis_tuser ? i_s_axis_tdata : '0;   // an invalid sample counts as zero
    assign req.hist_ok = (r_fcnt == r_win);                       // history has wrapped
    assign req.sum_ok  = (r_fcnt != '0);                          // first frame done

    // reset value of the emit countdown: (window - 1) / 2
    function automatic logic [WIN_W-2:0] win_m1_rst(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] m;
        m = w - 1'b1;
        return m[WIN_W-1:1];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= WINDOW_RST;
            r_step  <= STEP_RST;
            r_bins  <= BINS_RST;
            r_bin   <= '0;
            r_slot  <= WINDOW_RST[WIN_W-1:1];
            r_until <= STEP_W'(win_m1_rst(WINDOW_RST));
            r_fcnt  <= '0;
        end else if (cfg_hit) begin
            // any register write restarts the stream under the new settings
            r_win   <= n_win;
            r_step  <= n_step;
            r_bins  <= n_bins;
            r_bin   <= '0;
            r_slot  <= n_win[WIN_W-1:1];
            r_until <= STEP_W'(win_m1[WIN_W-1:1]);
            r_fcnt  <= '0;
        end else if (in_acc) begin
            if (is_last) begin
                r_bin   <= '0;
                r_slot  <= (slot_inc == r_win) ? '0 : slot_inc[SLOT_W-1:0];
                r_until <= emit_now ? (r_step - 1'b1) : (r_until - 1'b1);
                if (r_fcnt != r_win) begin
                    r_fcnt <= r_fcnt + 1'b1;
                end
            end else begin
                r_bin <= r_bin + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_emit      <= emit_now;
            r_emit_idx  <= IDX_W'(r_bin);
            r_emit_last <= is_last;
        end
    end

    // ---------------- control sequence ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        do_wr     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                // memory data arrived: write back, then divide if this frame emits
                do_wr = 1'b1;
                if (r_emit) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mean <= div_quot;
            r_out_idx  <= r_emit_idx;
            r_out_last <= r_emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-SAMPLE_W-IDX_W){1'b0}}, r_out_idx, r_out_mean};
    assign o_m_axis_tlast  = r_out_last;

    // ---------------- datapath units ----------------
    dwm_store u_store (
        .i_clk     (i_clk),
        .i_rd      (in_acc),
        .i_req     (req),
        .i_wr      (do_wr),
        .o_new_sum (new_sum)
    );

    dwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (new_sum),
        .i_divisor  (r_win),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

endmodule

[tb/decimated_window_mean_per_bin_core_test.sv]
// self-checking bench for decimated_window_mean_per_bin_core: directed table, then random phases
// needs dwm_pkg and the core; expected means come from the directed table or a predictor kept in this file
`timescale 1ns / 1ps

module decimated_window_mean_per_bin_core_test;
    import dwm_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int DRAIN_CYCLES  = 50;      // longer than one emitting item
    localparam int END_SETTLE    = 60;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int CALM_FROM     = 850;     // no idling on either side after this many items
    localparam int PHASE_CAP     = 260;
    localparam int SHOW_LIMIT    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    // one output item, fields as they appear on the master side
    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic [IDX_W-1:0]    bin;
        logic                last;
    } t_mean_item;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // a row of the directed table: a register write or an input item
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   sample;
        logic                  ok;
        bit                    typed;   // expectation written into the table
        bit                    has;     // typed row emits a mean
        t_mean_item            want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [SAMPLE_W-1:0]    i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    decimated_window_mean_per_bin_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor state: its own copy of registers, history and sums
    // ---------------------------------------------------------------
    logic [WIN_W-1:0]  win_reg;
    logic [STEP_W-1:0] step_reg;
    logic [BINS_W-1:0] bins_reg;
    int                hist_mem [HIST_DEPTH];
    longint            bin_sum [MAX_BINS];
    int unsigned       bin_pos;
    int unsigned       slot_pos;
    int unsigned       frames_left;   // frames still to go before the next emitting frame

    t_mean_item        means_due [$];
    t_stim_row         stim_rows [$];

    // what the item on the input bus carries besides its payload
    logic              pend_typed;
    logic              pend_has;
    t_mean_item        pend_want;

    int                bad_count = 0;
    int                cycle_count = 0;
    int                gap_odds = 4;   // one item in gap_odds is preceded by a gap, 0 = never
    logic              calm = 1'b0;

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // history, sums and counters back to their start values under the current registers
    function automatic void restart_means();
        int unsigned w;
        w = clamp_reg(win_reg, MAX_WINDOW);
        foreach (hist_mem[i]) hist_mem[i] = 0;
        foreach (bin_sum[i]) bin_sum[i] = 0;
        bin_pos     = 0;
        slot_pos    = (w / 2) % w;     // half a window of zero frames already in
        frames_left = (w - 1) / 2;
    endfunction

    function automatic void write_mean_reg(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW: win_reg  = data[WIN_W-1:0];
            REG_STEP:   step_reg = data[STEP_W-1:0];
            REG_BINS:   bins_reg = data[BINS_W-1:0];
            default:    return;          // unused index leaves everything alone
        endcase
        restart_means();
    endfunction

    // take one bin sample into the window; emits tells whether a mean comes out
    function automatic void predict_mean(input logic [SAMPLE_W-1:0] s, input logic ok,
                                         output bit emits, output t_mean_item r);
        int unsigned w;
        int unsigned nb;
        int unsigned b;
        int unsigned slot;
        int unsigned addr;
        longint      val;
        bit          last;
        w    = clamp_reg(win_reg, MAX_WINDOW);
        nb   = clamp_reg(bins_reg, MAX_BINS);
        b    = bin_pos;
        slot = slot_pos;
        if (b >= nb) b = 0;
        if (slot >= w) slot = 0;
        // an invalid sample enters the window as zero
        val  = ok ? longint'($signed(s)) : longint'(0);
        addr = slot * MAX_BINS + b;
        bin_sum[b] += val - longint'(hist_mem[addr]);
        hist_mem[addr] = int'(val);
        last   = (b + 1 == nb);
        emits  = (frames_left == 0);
        // signed divide truncates toward zero
        r.mean = SAMPLE_W'(bin_sum[b] / longint'(w));
        r.bin  = IDX_W'(b);
        r.last = last;
        if (last) begin
            bin_pos  = 0;
            slot_pos = (slot + 1) % w;
            if (emits) begin
                frames_left = clamp_reg(step_reg, MAX_STEP) - 1;
            end else begin
                frames_left = frames_left - 1;
            end
        end else begin
            bin_pos = b + 1;
        end
    endfunction

    // ---------------------------------------------------------------
    // directed table helpers
    // ---------------------------------------------------------------
    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '{kind: ROW_CFG, idx: idx, data: data, sample: '0, ok: 1'b0,
              typed: 1'b0, has: 1'b0, want: '0};
        stim_rows = {stim_rows, r};
    endfunction

    // item with its outcome written out; has = 0 means no mean may come out
    function automatic void add_typed(logic [SAMPLE_W-1:0] s, logic ok, bit has,
                                      logic [SAMPLE_W-1:0] m, logic [IDX_W-1:0] b, logic l);
        t_stim_row r;
        r = '{kind: ROW_ITEM, idx: '0, data: '0, sample: s, ok: ok,
              typed: 1'b1, has: has, want: '{mean: m, bin: b, last: l}};
        stim_rows = {stim_rows, r};
    endfunction

    // item left to the predictor
    function automatic void add_free(logic [SAMPLE_W-1:0] s, logic ok);
        t_stim_row r;
        r = '{kind: ROW_ITEM, idx: '0, data: '0, sample: s, ok: ok,
              typed: 1'b0, has: 1'b0, want: '0};
        stim_rows = {stim_rows, r};
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:           return 32'h7FFF_FFFF;
            1:           return 32'h8000_0000;
            2:           return '0;
            3:           return '1;
            4, 5, 6, 7,
            8, 9:        return $urandom;
            default:     return SAMPLE_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // register writes only once the block has gone quiet
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (means_due.size() != 0) @(posedge i_clk);
        // a non-emitting item may still be finishing its update
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    // tvalid stays high across back-to-back items unless a gap is drawn
    task automatic send_item(logic [SAMPLE_W-1:0] s, logic ok, bit typed, bit has,
                             t_mean_item want);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 12);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        i_s_axis_tuser  <= ok;
        pend_typed      <= typed;
        pend_has        <= has;
        pend_want       <= want;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
    endtask

    // receiver stalls in bursts, long ready stretches in between
    int ready_left = 0;
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_m_axis_tready <= 1'b1;
        end else if (ready_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                ready_left      <= $urandom_range(1, 12);
            end else begin
                i_m_axis_tready <= 1'b1;
                ready_left      <= $urandom_range(1, 24);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // checking: all handshakes seen at the same edge, inputs before outputs
    // ---------------------------------------------------------------
    function automatic void note_mismatch(string what, t_mean_item want, t_mean_item got);
        if (bad_count < SHOW_LIMIT) begin
            $display("cycle %0d: %s: expected mean %h bin %0d last %0b, got mean %h bin %0d last %0b",
                     cycle_count, what, want.mean, want.bin, want.last,
                     got.mean, got.bin, got.last);
        end
        bad_count++;
    endfunction

    always @(posedge i_clk) begin : watch
        bit         emits;
        t_mean_item calc;
        t_mean_item got;
        t_mean_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                write_mean_reg(i_cfg_index, i_cfg_data);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_mean(i_s_axis_tdata, i_s_axis_tuser, emits, calc);
                // typed rows override the predictor, which still has to absorb the item
                if (pend_typed) begin
                    if (pend_has) means_due = {means_due, pend_want};
                end else if (emits) begin
                    means_due = {means_due, calc};
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.mean = o_m_axis_tdata[SAMPLE_W-1:0];
                got.bin  = o_m_axis_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
                got.last = o_m_axis_tlast;
                if (means_due.size() == 0) begin
                    note_mismatch("mean with nothing expected", '0, got);
                end else begin
                    want = means_due.pop_front();
                    if (got.mean !== want.mean || got.bin !== want.bin
                            || got.last !== want.last) begin
                        note_mismatch("wrong mean item", want, got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin : run
        int          items_sent;
        int          n_items;
        int          mode;
        int unsigned w_eff;
        int unsigned s_eff;
        int unsigned b_eff;
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] s_raw;
        logic [CFG_DATA_W-1:0] b_raw;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_WINDOW;
        i_cfg_data      <= '0;
        pend_typed      <= 1'b0;
        pend_has        <= 1'b0;
        pend_want       <= '0;

        win_reg  = WINDOW_RST;
        step_reg = STEP_RST;
        bins_reg = BINS_RST;
        restart_means();

        // window of one frame: every sample comes straight back as its own mean
        add_cfg(REG_STEP, 1);
        add_cfg(REG_BINS, 3);
        add_cfg(REG_WINDOW, 0);                  // zero clamps to one
        add_typed(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 0, 1'b0);
        add_typed(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1, 1'b0);
        add_typed(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 2, 1'b1);
        add_typed(32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 0, 1'b0);  // invalid reads as zero
        add_typed(32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, 1, 1'b0);
        add_typed(32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 2, 1'b1);

        // step beyond its range clamps to 1024: one frame out, then silence
        add_cfg(REG_STEP, 11'h7FF);
        add_cfg(REG_UNUSED, 11'h7FF);            // must change nothing
        add_typed(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 0, 1'b0);
        add_typed(32'h4000_0000, 1'b1, 1'b1, 32'h4000_0000, 1, 1'b0);
        add_typed(32'h0000_0005, 1'b1, 1'b1, 32'h0000_0005, 2, 1'b1);
        add_typed(32'h0000_0007, 1'b1, 1'b0, '0, 0, 1'b0);
        add_typed(32'h8000_0000, 1'b1, 1'b0, '0, 0, 1'b0);
        add_typed(32'h7FFF_FFFF, 1'b0, 1'b0, '0, 0, 1'b0);

        // register extremes, then a two-frame window over single-bin frames
        add_cfg(REG_WINDOW, 255);
        add_cfg(REG_BINS, 200);
        add_cfg(REG_STEP, 1);
        add_cfg(REG_BINS, 0);
        add_cfg(REG_WINDOW, 2);
        add_typed(32'h8000_0000, 1'b1, 1'b1, 32'hC000_0000, 0, 1'b1);
        add_typed(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 0, 1'b1);  // most negative sum
        add_typed(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hC000_0000, 0, 1'b1);  // odd sum truncates up
        add_typed(32'h0000_0003, 1'b1, 1'b1, 32'h0000_0001, 0, 1'b1);
        add_typed(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0001, 0, 1'b1);

        // a three-frame window over full-scale samples: the sum needs more than 32 bits
        add_cfg(REG_WINDOW, 3);
        add_free(32'h7FFF_FFFF, 1'b1);
        add_free(32'h7FFF_FFFF, 1'b1);
        add_free(32'h8000_0000, 1'b1);
        add_free(32'h8000_0000, 1'b1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                cfg_write(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_item(stim_rows[i].sample, stim_rows[i].ok, stim_rows[i].typed,
                          stim_rows[i].has, stim_rows[i].want);
            end
        end

        // random phases: new settings, then whole frames up to and past the first
        // emitting frame, often ending mid-frame
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
                w_raw = CFG_DATA_W'($urandom_range(1, 8));
                b_raw = CFG_DATA_W'($urandom_range(1, 8));
                s_raw = CFG_DATA_W'($urandom_range(1, 6));
            end else if (mode == 6) begin
                // long windows over very short frames
                w_raw = CFG_DATA_W'($urandom_range(9, MAX_WINDOW));
                b_raw = CFG_DATA_W'($urandom_range(1, 3));
                s_raw = CFG_DATA_W'($urandom_range(1, w_raw + 4));
            end else if (mode == 7) begin
                // wide frames over short windows
                w_raw = CFG_DATA_W'($urandom_range(1, 2));
                b_raw = CFG_DATA_W'($urandom_range(100, MAX_BINS));
                s_raw = CFG_DATA_W'($urandom_range(1, 2));
            end else if (mode == 8) begin
                // raw register values, masked and clamped inside
                w_raw = CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1));
                b_raw = CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1));
                s_raw = CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1));
            end else begin
                // step longer than the window
                w_raw = CFG_DATA_W'($urandom_range(2, 5));
                b_raw = CFG_DATA_W'($urandom_range(1, 4));
                s_raw = CFG_DATA_W'($urandom_range(w_raw + 1, 12));
            end
            w_eff = clamp_reg(w_raw[WIN_W-1:0], MAX_WINDOW);
            b_eff = clamp_reg(b_raw[BINS_W-1:0], MAX_BINS);
            s_eff = clamp_reg(s_raw[STEP_W-1:0], MAX_STEP);

            if (!calm) begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 8;
                    default: gap_odds = 3;
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(REG_WINDOW, w_raw);
                cfg_write(REG_STEP, s_raw);
                cfg_write(REG_BINS, b_raw);
            end else begin
                cfg_write(REG_BINS, b_raw);
                cfg_write(REG_WINDOW, w_raw);
                cfg_write(REG_STEP, s_raw);
            end
            if ($urandom_range(0, 7) == 0) begin
                cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)));
            end

            n_items = b_eff * ((w_eff - 1) / 2 + 1 + s_eff * $urandom_range(0, 3))
                      + $urandom_range(0, b_eff - 1);
            if (n_items > PHASE_CAP) n_items = PHASE_CAP;

            for (int k = 0; k < n_items && items_sent < RANDOM_ITEMS; k++) begin
                send_item(pick_sample(), $urandom_range(0, 9) != 0, 1'b0, 1'b0, '0);
                items_sent++;
                if (items_sent == CALM_FROM) begin
                    calm    <= 1'b1;
                    gap_odds = 0;
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (means_due.size() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);

        if (means_due.size() != 0) begin
            $display("%0d expected means never arrived", means_due.size());
        end
        if (bad_count == 0 && means_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
